### hdl/assert_macros.svh
// Assertion macros used by the top level of the flash command splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another one in the same cycle.
`define ASSERT_IMPLIES(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("assertion failed: implication in the same cycle");

// Check that a condition implies another one in the following cycle.
`define ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("assertion failed: implication in the next cycle");

`endif

### hdl/spifcs_pkg.sv
// Types, codes and the device table of the flash command splitter.
package spifcs_pkg;

  // Request kinds.
  localparam logic [1:0] OP_READ     = 2'd0;
  localparam logic [1:0] OP_WRITE    = 2'd1;
  localparam logic [1:0] OP_ERASE    = 2'd2;
  localparam logic [1:0] OP_IDENTIFY = 2'd3;

  // SPI opcodes carried in the descriptors.
  localparam logic [7:0] CMD_NONE    = 8'h00;
  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] CMD_PROGRAM = 8'h02;
  localparam logic [7:0] CMD_ERASE   = 8'h20;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
  localparam logic [1:0] STATUS_NO_MATCH = 2'd2;

  localparam int unsigned NumParts = 4;

  // One request as it arrives.
  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] byte_offset;
    logic [13:0] byte_length;
    logic [7:0]  manufacturer_id;
    logic [7:0]  part_id;
  } req_t;

  // One command descriptor as it leaves.
  typedef struct packed {
    logic [7:0]  command_code;
    logic [23:0] flash_address;
    logic [13:0] byte_count;
    logic [12:0] buffer_index;
    logic        wait_before;
    logic        enable_before;
    logic        wait_after;
    logic [1:0]  status;
    logic [21:0] device_size;
    logic        last;
  } res_t;

  // How the back end expands a job into descriptors.
  typedef enum logic [1:0] {
    JOB_SINGLE,
    JOB_PROGRAM,
    JOB_ERASE
  } job_kind_e;

  // A classified request. The address is kept one bit wider so that the
  // erase walk can compare against the unwrapped end address.
  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  code;
    logic [24:0] addr;
    logic [24:0] end_addr;
    logic [13:0] left;
    logic [1:0]  status;
    logic        wait_before;
    logic [21:0] device_size;
  } job_t;

  typedef struct packed {
    logic [21:0] size;
    logic [7:0]  manuf;
    logic [7:0]  dev;
  } part_t;

  localparam part_t PartTable [NumParts] = '{
    '{size: 22'h200000, manuf: 8'hC2, dev: 8'h15},
    '{size: 22'h100000, manuf: 8'hC2, dev: 8'h14},
    '{size: 22'h080000, manuf: 8'hEF, dev: 8'h12},
    '{size: 22'h040000, manuf: 8'hEF, dev: 8'h11}
  };

  // Size of the matching part, or zero when the IDs are not known.
  function automatic logic [21:0] part_size(logic [7:0] manuf, logic [7:0] dev);
    logic [21:0] found;
    found = '0;
    for (int i = NumParts - 1; i >= 0; i--) begin
      if (PartTable[i].manuf == manuf && PartTable[i].dev == dev) begin
        found = PartTable[i].size;
      end
    end
    return found;
  endfunction

endpackage

### hdl/spifcs_stream_if.sv
// Valid/ready stream channel carrying one payload of a chosen type.
interface spifcs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/spifcs_front.sv
// Front end: accepts requests, checks lengths, identifies parts, forms jobs.
module spifcs_front #(
  parameter int unsigned SECTOR_BYTES = 4096,
  parameter int unsigned MAX_LENGTH   = 8192
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  spifcs_stream_if.sink    req_i,
  spifcs_stream_if.source  job_o
);

  localparam logic [13:0] MaxLen     = 14'(MAX_LENGTH);
  localparam logic [23:0] SectorMask = 24'(SECTOR_BYTES - 1);

  logic [21:0]        size_q, size_d;
  logic [21:0]        lookup;
  logic               bad_len;
  spifcs_pkg::req_t   req;
  spifcs_pkg::job_t   job;

  assign req     = req_i.payload;
  assign lookup  = spifcs_pkg::part_size(req.manufacturer_id, req.part_id);
  assign bad_len = (req.byte_length == '0) || (req.byte_length > MaxLen);

  // A request passes straight into the queue when it has room.
  assign job_o.valid   = req_i.valid;
  assign req_i.ready   = job_o.ready;
  assign job_o.payload = job;

  // Classify the request into a job for the back end.
  always_comb begin
    size_d          = size_q;
    job.kind        = spifcs_pkg::JOB_SINGLE;
    job.code        = spifcs_pkg::CMD_NONE;
    job.addr        = '0;
    job.end_addr    = '0;
    job.left        = '0;
    job.status      = spifcs_pkg::STATUS_OK;
    job.wait_before = 1'b0;
    job.device_size = size_q;
    priority if (req.op == spifcs_pkg::OP_IDENTIFY) begin
      size_d          = lookup;
      job.device_size = lookup;
      job.status      = (lookup != '0) ? spifcs_pkg::STATUS_OK : spifcs_pkg::STATUS_NO_MATCH;
    end else if (req.op == spifcs_pkg::OP_ERASE && req.byte_length == '0) begin
      // Nothing to erase: a single empty descriptor that reports success.
      job.status = spifcs_pkg::STATUS_OK;
    end else if (bad_len) begin
      job.status = spifcs_pkg::STATUS_BAD_LEN;
    end else if (req.op == spifcs_pkg::OP_READ) begin
      job.code        = spifcs_pkg::CMD_READ;
      job.addr        = {1'b0, req.byte_offset};
      job.left        = req.byte_length;
      job.wait_before = 1'b1;
    end else if (req.op == spifcs_pkg::OP_WRITE) begin
      job.kind = spifcs_pkg::JOB_PROGRAM;
      job.addr = {1'b0, req.byte_offset};
      job.left = req.byte_length;
    end else begin
      job.kind     = spifcs_pkg::JOB_ERASE;
      job.addr     = {1'b0, req.byte_offset & ~SectorMask};
      job.end_addr = {1'b0, req.byte_offset} + 25'(req.byte_length) - 25'd1;
    end
  end

  // The identified size follows every accepted identify transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (req_i.valid && req_i.ready) begin
      size_q <= size_d;
    end
  end

endmodule

### hdl/spifcs_fifo.sv
// Two-entry job queue between the front end and the back end.
module spifcs_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  spifcs_stream_if.sink    in_i,
  spifcs_stream_if.source  out_o
);

  localparam int unsigned Depth = 2;

  spifcs_pkg::job_t entries_q [Depth];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             push, pop;

  assign in_i.ready    = (count_q != 2'(Depth));
  assign out_o.valid   = (count_q != '0);
  assign out_o.payload = entries_q[rd_ptr_q];
  assign push          = in_i.valid && in_i.ready;
  assign pop           = out_o.valid && out_o.ready;

  // Entry storage; the payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= in_i.payload;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hdl/spifcs_back.sv
// Back end: expands one job into command descriptors, one per cycle while the output is free.
module spifcs_back #(
  parameter int unsigned PAGE_BYTES   = 256,
  parameter int unsigned SECTOR_BYTES = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  spifcs_stream_if.sink    job_i,
  spifcs_stream_if.source  res_o
);

  localparam logic [23:0] PageMask  = 24'(PAGE_BYTES - 1);
  localparam logic [13:0] PageSize  = 14'(PAGE_BYTES);
  localparam logic [24:0] SectorLen = 25'(SECTOR_BYTES);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e           state_q;
  spifcs_pkg::job_t cur_q;
  logic [12:0]      bidx_q;
  logic             res_valid_q;
  spifcs_pkg::res_t res_q, res_d;

  logic [13:0]      room, chunk;
  logic [24:0]      span;
  logic             final_erase, done;
  logic             slot_free;
  spifcs_pkg::job_t next_cur;

  assign slot_free     = !res_valid_q || res_o.ready;
  assign job_i.ready   = (state_q == ST_IDLE);
  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  // Page split: the chunk stops at the next page boundary.
  assign room  = PageSize - 14'(cur_q.addr[23:0] & PageMask);
  assign chunk = (cur_q.left < room) ? cur_q.left : room;

  // Erase walk: this sector is the last one when the end lies inside it.
  assign span        = cur_q.end_addr - cur_q.addr;
  assign final_erase = (span < SectorLen);

  // Descriptor for the current step and the job state after it.
  always_comb begin
    res_d               = '0;
    res_d.device_size   = cur_q.device_size;
    res_d.flash_address = cur_q.addr[23:0];
    next_cur            = cur_q;
    done                = 1'b1;
    unique case (cur_q.kind)
      spifcs_pkg::JOB_PROGRAM: begin
        res_d.command_code  = spifcs_pkg::CMD_PROGRAM;
        res_d.byte_count    = chunk;
        res_d.buffer_index  = bidx_q;
        res_d.wait_before   = 1'b1;
        res_d.enable_before = 1'b1;
        done                = (cur_q.left == chunk);
        next_cur.addr       = {1'b0, cur_q.addr[23:0] + 24'(chunk)};
        next_cur.left       = cur_q.left - chunk;
      end
      spifcs_pkg::JOB_ERASE: begin
        res_d.command_code  = spifcs_pkg::CMD_ERASE;
        res_d.wait_before   = 1'b1;
        res_d.enable_before = 1'b1;
        res_d.wait_after    = final_erase;
        done                = final_erase;
        next_cur.addr       = cur_q.addr + SectorLen;
      end
      default: begin
        res_d.command_code = cur_q.code;
        res_d.byte_count   = cur_q.left;
        res_d.wait_before  = cur_q.wait_before;
        res_d.status       = cur_q.status;
      end
    endcase
    res_d.last = done;
  end

  // Sequencer state, job registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      cur_q       <= '0;
      bidx_q      <= '0;
      res_q       <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          // The final descriptor of the previous job may still be waiting.
          if (res_o.ready) begin
            res_valid_q <= 1'b0;
          end
          if (job_i.valid) begin
            cur_q   <= job_i.payload;
            bidx_q  <= '0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            res_q       <= res_d;
            res_valid_q <= 1'b1;
            cur_q       <= next_cur;
            bidx_q      <= bidx_q + 13'(chunk);
            if (done) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### hdl/spi_flash_command_splitter_core.sv
// Top level of the SPI NOR flash command splitter.
// A request is queued at the edge it is accepted; the back end loads it from the queue
// when idle, and its first descriptor is registered at the output once the output is free.
// The back end does one job load, then gives one descriptor per cycle while the output
// is free, up to 33 descriptors for one request; it takes no new job until the last.
// Reset clears the queue, the sequencer, the output valid and the identified size.
`include "assert_macros.svh"

module spi_flash_command_splitter_core #(
  parameter int unsigned PAGE_BYTES   = 256,
  parameter int unsigned SECTOR_BYTES = 4096,
  parameter int unsigned MAX_LENGTH   = 8192
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  spifcs_stream_if.sink    req_i,
  spifcs_stream_if.source  res_o
);

  spifcs_stream_if #(.T(spifcs_pkg::job_t)) front_job ();
  spifcs_stream_if #(.T(spifcs_pkg::job_t)) queued_job ();

  // Request classification and part identification.
  spifcs_front #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .MAX_LENGTH   (MAX_LENGTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .job_o  (front_job)
  );

  // Job queue decoupling the two halves.
  spifcs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (front_job),
    .out_o  (queued_job)
  );

  // Descriptor generation.
  spifcs_back #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (queued_job),
    .res_o  (res_o)
  );

  // A failed identify carries no command and clears the device size.
  `ASSERT_IMPLIES(a_no_match_empty, clk_i, rst_ni,
    res_o.valid && res_o.payload.status == spifcs_pkg::STATUS_NO_MATCH,
    res_o.payload.command_code == spifcs_pkg::CMD_NONE && res_o.payload.device_size == '0)

  // A bad length ends its request with no command.
  `ASSERT_IMPLIES(a_bad_len_single, clk_i, rst_ni,
    res_o.valid && res_o.payload.status == spifcs_pkg::STATUS_BAD_LEN,
    res_o.payload.last && res_o.payload.command_code == spifcs_pkg::CMD_NONE)

  // Only the final erase of a request polls afterwards, and erases move no data.
  `ASSERT_IMPLIES(a_erase_tail, clk_i, rst_ni,
    res_o.valid && res_o.payload.command_code == spifcs_pkg::CMD_ERASE,
    res_o.payload.wait_after == res_o.payload.last && res_o.payload.byte_count == '0)

  // Every page program moves at least one byte and no more than a page.
  `ASSERT_IMPLIES(a_program_chunk, clk_i, rst_ni,
    res_o.valid && res_o.payload.command_code == spifcs_pkg::CMD_PROGRAM,
    res_o.payload.byte_count != '0 && res_o.payload.byte_count <= 14'(PAGE_BYTES))

endmodule

### verif/tb.sv
// Self-checking testbench for the SPI NOR flash command splitter core.
module tb;

  localparam int unsigned PageBytes   = 256;
  localparam int unsigned SectorBytes = 4096;
  localparam int unsigned MaxLength   = 8192;
  localparam int unsigned RandomItems = 147;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned AddrMask    = 32'h00FF_FFFF;

  // Known parts, kept apart from the design's own table.
  localparam logic [21:0] PartSize  [4] = '{22'h200000, 22'h100000, 22'h080000, 22'h040000};
  localparam logic [7:0]  PartManuf [4] = '{8'hC2, 8'hC2, 8'hEF, 8'hEF};
  localparam logic [7:0]  PartDev   [4] = '{8'h15, 8'h14, 8'h12, 8'h11};

  // One row of the directed table; typed rows carry their single descriptor.
  typedef struct {
    spifcs_pkg::req_t req;
    bit               typed;
    spifcs_pkg::res_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  spifcs_stream_if #(.T(spifcs_pkg::req_t)) req_if ();
  spifcs_stream_if #(.T(spifcs_pkg::res_t)) res_if ();

  spi_flash_command_splitter_core #(
    .PAGE_BYTES  (PageBytes),
    .SECTOR_BYTES(SectorBytes),
    .MAX_LENGTH  (MaxLength)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  spifcs_pkg::res_t desc_q [$];
  dir_row_t         dir_rows [$];
  logic [21:0]      known_size = '0;
  bit               steady_flow = 1'b0;
  int unsigned      mismatches = 0;
  int unsigned      descs_seen = 0;
  int unsigned      cycles = 0;
  int unsigned      op_count [4] = '{0, 0, 0, 0};

  // Free-running clock.
  always #5 clk_i = ~clk_i;

  // Hard stop should the block hang.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly back to back, sometimes a few cycles, now and then a long pause.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (steady_flow || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic spifcs_pkg::res_t mk_desc(logic [7:0] code, logic [23:0] addr,
                                               logic [13:0] count, logic [12:0] bidx,
                                               logic wb, logic eb, logic wa,
                                               logic [1:0] st, logic [21:0] size,
                                               logic fin);
    spifcs_pkg::res_t d;
    d.command_code  = code;
    d.flash_address = addr;
    d.byte_count    = count;
    d.buffer_index  = bidx;
    d.wait_before   = wb;
    d.enable_before = eb;
    d.wait_after    = wa;
    d.status        = st;
    d.device_size   = size;
    d.last          = fin;
    return d;
  endfunction

  // Expands one request into the command descriptors it should produce.
  function automatic void split_request(input spifcs_pkg::req_t r,
                                        ref spifcs_pkg::res_t out [$]);
    int unsigned off, len, addr, left, chunk, bidx, first, last_byte, nsect;
    logic [21:0] found;
    logic        fin;
    off = 32'(r.byte_offset);
    len = 32'(r.byte_length);
    if (r.op == spifcs_pkg::OP_IDENTIFY) begin
      found = '0;
      for (int i = 0; i < 4; i++) begin
        if (found == '0 && PartManuf[i] == r.manufacturer_id && PartDev[i] == r.part_id) begin
          found = PartSize[i];
        end
      end
      known_size = found;
      out.push_back(mk_desc(spifcs_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0,
                            (found != '0) ? spifcs_pkg::STATUS_OK : spifcs_pkg::STATUS_NO_MATCH,
                            known_size, 1'b1));
    end else if (r.op == spifcs_pkg::OP_ERASE && len == 0) begin
      // An empty erase succeeds without issuing anything.
      out.push_back(mk_desc(spifcs_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0,
                            spifcs_pkg::STATUS_OK, known_size, 1'b1));
    end else if (len == 0 || len > MaxLength) begin
      out.push_back(mk_desc(spifcs_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0,
                            spifcs_pkg::STATUS_BAD_LEN, known_size, 1'b1));
    end else if (r.op == spifcs_pkg::OP_READ) begin
      out.push_back(mk_desc(spifcs_pkg::CMD_READ, r.byte_offset, r.byte_length, '0, 1'b1,
                            1'b0, 1'b0, spifcs_pkg::STATUS_OK, known_size, 1'b1));
    end else if (r.op == spifcs_pkg::OP_WRITE) begin
      // Cut at page boundaries; the address wraps at 24 bits.
      addr = off;
      left = len;
      bidx = 0;
      while (left > 0) begin
        chunk = PageBytes - (addr % PageBytes);
        if (left < chunk) chunk = left;
        left -= chunk;
        out.push_back(mk_desc(spifcs_pkg::CMD_PROGRAM, 24'(addr), 14'(chunk), 13'(bidx),
                              1'b1, 1'b1, 1'b0, spifcs_pkg::STATUS_OK, known_size,
                              left == 0));
        addr = (addr + chunk) & AddrMask;
        bidx += chunk;
      end
    end else begin
      // One erase per sector touched, counted on the unwrapped end address.
      first     = (off / SectorBytes) * SectorBytes;
      last_byte = off + len - 1;
      nsect     = (last_byte - first + SectorBytes) / SectorBytes;
      addr      = first;
      for (int unsigned i = 0; i < nsect; i++) begin
        fin = (i + 1 == nsect);
        out.push_back(mk_desc(spifcs_pkg::CMD_ERASE, 24'(addr), '0, '0, 1'b1, 1'b1, fin,
                              spifcs_pkg::STATUS_OK, known_size, fin));
        addr = (addr + SectorBytes) & AddrMask;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at descriptor %0d, %s: got 0x%0h, expected 0x%0h",
             descs_seen, what, got, want);
    mismatches++;
  endtask

  // Compares one received descriptor with the oldest outstanding one.
  task automatic check_desc(input spifcs_pkg::res_t got);
    spifcs_pkg::res_t want;
    if (desc_q.size() == 0) begin
      report_mismatch("descriptor with none outstanding", 32'(got.command_code), '0);
    end else begin
      want = desc_q.pop_front();
      if (got.command_code !== want.command_code)
        report_mismatch("command_code", 32'(got.command_code), 32'(want.command_code));
      if (got.flash_address !== want.flash_address)
        report_mismatch("flash_address", 32'(got.flash_address), 32'(want.flash_address));
      if (got.byte_count !== want.byte_count)
        report_mismatch("byte_count", 32'(got.byte_count), 32'(want.byte_count));
      if (got.buffer_index !== want.buffer_index)
        report_mismatch("buffer_index", 32'(got.buffer_index), 32'(want.buffer_index));
      if (got.wait_before !== want.wait_before)
        report_mismatch("wait_before", 32'(got.wait_before), 32'(want.wait_before));
      if (got.enable_before !== want.enable_before)
        report_mismatch("enable_before", 32'(got.enable_before), 32'(want.enable_before));
      if (got.wait_after !== want.wait_after)
        report_mismatch("wait_after", 32'(got.wait_after), 32'(want.wait_after));
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.device_size !== want.device_size)
        report_mismatch("device_size", 32'(got.device_size), 32'(want.device_size));
      if (got.last !== want.last)
        report_mismatch("last", 32'(got.last), 32'(want.last));
    end
    descs_seen++;
  endtask

  // Every completed output transaction is checked at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      check_desc(res_if.payload);
    end
  end

  // Receiver: ready drops for random stretches.
  initial begin : sink_side
    int unsigned hold;
    hold = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        hold--;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = idle_len();
      end
    end
  end

  task automatic add_row(input logic [1:0] op, input logic [23:0] off, input logic [13:0] len,
                         input logic [7:0] mid, input logic [7:0] pid, input bit typed,
                         input spifcs_pkg::res_t want);
    dir_row_t row;
    row.req.op              = op;
    row.req.byte_offset     = off;
    row.req.byte_length     = len;
    row.req.manufacturer_id = mid;
    row.req.part_id         = pid;
    row.typed               = typed;
    row.want                = want;
    dir_rows.push_back(row);
  endtask

  // Presents one request after a random gap and records what it should produce.
  task automatic send_request(input spifcs_pkg::req_t r, input bit typed,
                              input spifcs_pkg::res_t want);
    spifcs_pkg::res_t fresh [$];
    int unsigned      gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    split_request(r, fresh);
    if (typed) desc_q.push_back(want);
    else foreach (fresh[i]) desc_q.push_back(fresh[i]);
    op_count[r.op]++;
  endtask

  initial begin : stimulus
    spifcs_pkg::req_t r;
    spifcs_pkg::res_t bad_len;
    spifcs_pkg::res_t none;
    int unsigned      pick;
    int unsigned      k;

    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;

    bad_len = mk_desc(spifcs_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0,
                      spifcs_pkg::STATUS_BAD_LEN, '0, 1'b1);
    none    = '0;

    // Directed table: extremes, error cases, identify table, wrap and splits.
    add_row(spifcs_pkg::OP_READ, 24'h000000, 14'd1, 8'h00, 8'h00, 1'b1,
            mk_desc(spifcs_pkg::CMD_READ, 24'h000000, 14'd1, '0, 1'b1, 1'b0, 1'b0,
                    spifcs_pkg::STATUS_OK, '0, 1'b1));
    add_row(spifcs_pkg::OP_READ, 24'hFFFFFF, 14'd8192, 8'hFF, 8'hFF, 1'b1,
            mk_desc(spifcs_pkg::CMD_READ, 24'hFFFFFF, 14'd8192, '0, 1'b1, 1'b0, 1'b0,
                    spifcs_pkg::STATUS_OK, '0, 1'b1));
    add_row(spifcs_pkg::OP_READ, 24'h123456, 14'd0, 8'h00, 8'h00, 1'b1, bad_len);
    add_row(spifcs_pkg::OP_READ, 24'hFFFFFF, 14'h3FFF, 8'h00, 8'h00, 1'b1, bad_len);
    add_row(spifcs_pkg::OP_WRITE, 24'h000100, 14'd0, 8'h00, 8'h00, 1'b1, bad_len);
    add_row(spifcs_pkg::OP_WRITE, 24'h000000, 14'd8193, 8'h00, 8'h00, 1'b1, bad_len);
    add_row(spifcs_pkg::OP_ERASE, 24'hABCDEF, 14'd0, 8'h00, 8'h00, 1'b1,
            mk_desc(spifcs_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0,
                    spifcs_pkg::STATUS_OK, '0, 1'b1));
    add_row(spifcs_pkg::OP_ERASE, 24'h000000, 14'h3FFF, 8'h00, 8'h00, 1'b1, bad_len);
    add_row(spifcs_pkg::OP_IDENTIFY, 24'h000000, 14'd0, 8'hC2, 8'h15, 1'b1,
            mk_desc(spifcs_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0,
                    spifcs_pkg::STATUS_OK, 22'h200000, 1'b1));
    add_row(spifcs_pkg::OP_IDENTIFY, 24'h000000, 14'd0, 8'hC2, 8'h14, 1'b0, none);
    add_row(spifcs_pkg::OP_IDENTIFY, 24'hFFFFFF, 14'h3FFF, 8'hEF, 8'h12, 1'b0, none);
    add_row(spifcs_pkg::OP_IDENTIFY, 24'h000000, 14'd0, 8'hEF, 8'h11, 1'b0, none);
    add_row(spifcs_pkg::OP_IDENTIFY, 24'h000000, 14'd0, 8'h00, 8'h00, 1'b1,
            mk_desc(spifcs_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0,
                    spifcs_pkg::STATUS_NO_MATCH, '0, 1'b1));
    add_row(spifcs_pkg::OP_IDENTIFY, 24'h000000, 14'd0, 8'hFF, 8'hFF, 1'b1,
            mk_desc(spifcs_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b0,
                    spifcs_pkg::STATUS_NO_MATCH, '0, 1'b1));
    add_row(spifcs_pkg::OP_IDENTIFY, 24'h000000, 14'd0, 8'hC2, 8'h14, 1'b0, none);
    add_row(spifcs_pkg::OP_WRITE, 24'h000000, 14'd256, 8'h00, 8'h00, 1'b0, none);
    add_row(spifcs_pkg::OP_WRITE, 24'hFFFFF0, 14'd64, 8'h00, 8'h00, 1'b0, none);
    add_row(spifcs_pkg::OP_WRITE, 24'h123481, 14'd8192, 8'hFF, 8'hFF, 1'b0, none);
    add_row(spifcs_pkg::OP_WRITE, 24'h0000FF, 14'd1, 8'h00, 8'h00, 1'b0, none);
    add_row(spifcs_pkg::OP_ERASE, 24'h000FFF, 14'd2, 8'h00, 8'h00, 1'b0, none);
    add_row(spifcs_pkg::OP_ERASE, 24'hFFFFFF, 14'd8192, 8'h00, 8'h00, 1'b0, none);
    add_row(spifcs_pkg::OP_ERASE, 24'h000000, 14'd4096, 8'h00, 8'h00, 1'b0, none);
    add_row(spifcs_pkg::OP_READ, 24'hABCDEF, 14'd8191, 8'h5A, 8'hA5, 1'b0, none);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // Random requests, with a stretch in the middle where neither side idles.
    for (int n = 0; n < RandomItems; n++) begin
      steady_flow = (n >= 60 && n < 90);
      r.op = 2'($urandom_range(0, 3));

      pick = $urandom_range(0, 99);
      if (pick < 5) r.byte_length = '0;
      else if (pick < 12) r.byte_length = 14'($urandom_range(MaxLength + 1, 16383));
      else if (pick < 16) r.byte_length = 14'(MaxLength);
      else if (pick < 28) r.byte_length = 14'($urandom_range(1024, MaxLength));
      else r.byte_length = 14'($urandom_range(1, 600));

      // Offsets biased towards page ends, sector ends and the top of the space.
      pick = $urandom_range(0, 99);
      if (pick < 45) r.byte_offset = 24'($urandom);
      else if (pick < 65) r.byte_offset = (24'($urandom) | 24'h0000FF) -
                                          24'($urandom_range(0, 15));
      else if (pick < 80) r.byte_offset = (24'($urandom) | 24'h000FFF) -
                                          24'($urandom_range(0, 31));
      else r.byte_offset = 24'hFFFFFF - 24'($urandom_range(0, 8191));

      // Identify mostly names a known part; the rest are stray IDs.
      pick = $urandom_range(0, 99);
      if (r.op == spifcs_pkg::OP_IDENTIFY && pick < 70) begin
        k = $urandom_range(0, 3);
        r.manufacturer_id = PartManuf[k];
        r.part_id         = PartDev[k];
      end else if (r.op == spifcs_pkg::OP_IDENTIFY && pick < 80) begin
        r.manufacturer_id = '0;
        r.part_id         = '0;
      end else begin
        r.manufacturer_id = 8'($urandom);
        r.part_id         = 8'($urandom);
      end
      send_request(r, 1'b0, none);
    end
    steady_flow = 1'b0;

    @(negedge clk_i);
    req_if.valid <= 1'b0;

    // Drain, then give the block time to show any stray descriptor.
    while (desc_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests: %0d read, %0d write, %0d erase, %0d identify.",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("Compared %0d descriptors across page, sector and wrap splits; %0d mismatches.",
             descs_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
